// ===== rtl/core/tdcms_pkg.sv =====
// shared types and constants of the two-dimensional count-min sketch
`default_nettype none
package tdcms_pkg;

  localparam int KEY_W      = 32;
  localparam int WEIGHT_W   = 24;
  localparam int COUNT_W    = 32;
  localparam int MUL_W      = 5;
  localparam int ADD_W      = 5;
  localparam int BUCK_W     = 6;
  localparam int DECAY_W    = 17;
  localparam int KIND_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;
  localparam int DATA_IN_W  = 2 * KEY_W + WEIGHT_W;

  // key * mul + add fits here without wrapping
  localparam int PROD_W     = KEY_W + MUL_W + 1;
  localparam int MOD_DIGITS = 4;
  localparam int MOD_STEPS  = (PROD_W + MOD_DIGITS - 1) / MOD_DIGITS;
  localparam int MOD_PAD_W  = MOD_STEPS * MOD_DIGITS;
  localparam int MOD_CNT_W  = $clog2(MOD_STEPS);

  localparam int DPROD_W    = COUNT_W + DECAY_W;

  localparam logic [DECAY_W-1:0] DECAY_ONE = 17'h10000;

  localparam logic [MUL_W-1:0]   MUL0_RST  = 5'd1;
  localparam logic [ADD_W-1:0]   ADD0_RST  = 5'd0;
  localparam logic [MUL_W-1:0]   MUL1_RST  = 5'd3;
  localparam logic [ADD_W-1:0]   ADD1_RST  = 5'd7;
  localparam logic [BUCK_W-1:0]  BUCK_RST  = 6'd32;
  localparam logic [DECAY_W-1:0] DECAY_RST = 17'd32768;

  typedef enum logic [KIND_W-1:0] {
    REQ_INSERT = 2'd0,
    REQ_QUERY  = 2'd1,
    REQ_DECAY  = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MUL0  = 3'd0,
    CFG_ADD0  = 3'd1,
    CFG_MUL1  = 3'd2,
    CFG_ADD1  = 3'd3,
    CFG_BUCK  = 3'd4,
    CFG_DECAY = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic              start;
    logic [PROD_W-1:0] dividend;
  } mod_req_t;

endpackage
`default_nettype wire

// ===== rtl/core/tdcms_mod_unit.sv =====
// iterative modulo unit, four remainder digits per cycle
`default_nettype none
module tdcms_mod_unit #(
  parameter int MAX_BUCKETS = 32
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire tdcms_pkg::mod_req_t                   req,
  input  wire logic [$clog2(MAX_BUCKETS+1)-1:0]      modulus,
  output logic                                       done,
  output logic [$clog2(MAX_BUCKETS)-1:0]             remainder
);

  localparam int NW = $clog2(MAX_BUCKETS + 1);
  localparam int BW = $clog2(MAX_BUCKETS);

  logic                                busy;
  logic [tdcms_pkg::MOD_CNT_W-1:0]     cnt;
  logic [tdcms_pkg::MOD_PAD_W-1:0]     sh;
  logic [tdcms_pkg::MOD_PAD_W-1:0]     sh_next;
  logic [NW-1:0]                       r;
  logic [NW-1:0]                       r_next;
  logic [NW-1:0]                       n;

  always_comb begin
    logic [NW:0] t;
    sh_next = sh;
    r_next  = r;
    for (int k = 0; k < tdcms_pkg::MOD_DIGITS; k++) begin
      t = {r_next, sh_next[tdcms_pkg::MOD_PAD_W-1]};
      sh_next = {sh_next[tdcms_pkg::MOD_PAD_W-2:0], 1'b0};
      if (t >= {1'b0, n}) begin
        t = t - {1'b0, n};
      end
      r_next = t[NW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= tdcms_pkg::MOD_CNT_W'(tdcms_pkg::MOD_STEPS - 1);
        sh   <= {{(tdcms_pkg::MOD_PAD_W - tdcms_pkg::PROD_W){1'b0}}, req.dividend};
        r    <= '0;
        n    <= modulus;
      end else if (busy) begin
        sh  <= sh_next;
        r   <= r_next;
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign remainder = r[BW-1:0];

endmodule
`default_nettype wire

// ===== rtl/core/tdcms_table.sv =====
// count table memory, one write port and one registered read port
`default_nettype none
module tdcms_table #(
  parameter int DEPTH = 2048
) (
  input  wire logic                              clk,
  input  wire logic                              we,
  input  wire logic [$clog2(DEPTH)-1:0]          waddr,
  input  wire logic [tdcms_pkg::COUNT_W-1:0]     wdata,
  input  wire logic [$clog2(DEPTH)-1:0]          raddr,
  output logic [tdcms_pkg::COUNT_W-1:0]          rdata
);

  logic [tdcms_pkg::COUNT_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/core/two_dim_count_min_sketch.sv =====
// two-dimensional count-min sketch: sequencer, config registers, hash and table update
// insert and query: per row two 10-step modulo passes (source key, then destination key),
//   then a read and an update; the rows take turns on the shared modulo unit
// decay: read, multiply and write for each cell in turn; clear: one write per cell
// one item at a time; the result register lets the next item in while a result waits
// rst is synchronous; after it the table is zeroed one cell at a time,
//   during which no item is accepted (config writes are)
`default_nettype none
module two_dim_count_min_sketch #(
  parameter int ROWS        = 2,
  parameter int MAX_BUCKETS = 32
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [tdcms_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [tdcms_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire logic                                 s_axis_tvalid,
  output logic                                      s_axis_tready,
  // src_key, dst_key, weight
  input  wire logic [tdcms_pkg::DATA_IN_W-1:0]      s_axis_tdata,
  // req_type
  input  wire logic [tdcms_pkg::KIND_W-1:0]         s_axis_tuser,
  output logic                                      m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  // count_value
  output logic [tdcms_pkg::COUNT_W-1:0]             m_axis_tdata,
  // done_kind
  output logic [tdcms_pkg::KIND_W-1:0]              m_axis_tuser
);

  localparam int DEPTH = ROWS * MAX_BUCKETS * MAX_BUCKETS;
  localparam int AW    = $clog2(DEPTH);
  localparam int NW    = $clog2(MAX_BUCKETS + 1);
  localparam int BW    = $clog2(MAX_BUCKETS);
  localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;

  typedef enum logic [3:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_MUL,
    ST_MODGO,
    ST_MODWAIT,
    ST_RD,
    ST_UPD,
    ST_DRD,
    ST_DMUL,
    ST_DWR,
    ST_OUT
  } state_t;

  state_t state;

  logic [tdcms_pkg::MUL_W-1:0]    mul0;
  logic [tdcms_pkg::ADD_W-1:0]    add0;
  logic [tdcms_pkg::MUL_W-1:0]    mul1;
  logic [tdcms_pkg::ADD_W-1:0]    add1;
  logic [tdcms_pkg::BUCK_W-1:0]   buckets;
  logic [tdcms_pkg::DECAY_W-1:0]  decay;

  tdcms_pkg::req_kind_t           kind;
  logic [tdcms_pkg::KEY_W-1:0]    src;
  logic [tdcms_pkg::KEY_W-1:0]    dst;
  logic [tdcms_pkg::WEIGHT_W-1:0] weight;
  logic                           sweep_reply;
  logic [RW-1:0]                  row;
  logic                           side;
  logic [BW-1:0]                  sb;
  logic [BW-1:0]                  db;
  logic [AW-1:0]                  addr;
  logic [tdcms_pkg::PROD_W-1:0]   prod;
  logic [tdcms_pkg::DPROD_W-1:0]  dprod;
  logic [tdcms_pkg::COUNT_W-1:0]  best;

  logic [tdcms_pkg::KEY_W-1:0]    key_sel;
  logic [tdcms_pkg::MUL_W-1:0]    mul_sel;
  logic [tdcms_pkg::ADD_W-1:0]    add_sel;
  logic [tdcms_pkg::PROD_W-1:0]   prod_calc;
  logic [tdcms_pkg::DECAY_W-1:0]  factor;
  logic [tdcms_pkg::DPROD_W-1:0]  dprod_calc;
  logic [7:0]                     buck_ext;
  logic [NW-1:0]                  n_eff;
  logic [AW-1:0]                  cell_addr;
  logic [tdcms_pkg::COUNT_W:0]    sat_sum;
  logic [tdcms_pkg::COUNT_W-1:0]  sat_val;

  tdcms_pkg::mod_req_t            mod_req;
  logic                           mod_done;
  logic [BW-1:0]                  mod_rem;

  logic                           mem_we;
  logic [AW-1:0]                  mem_waddr;
  logic [tdcms_pkg::COUNT_W-1:0]  mem_wdata;
  logic [AW-1:0]                  mem_raddr;
  logic [tdcms_pkg::COUNT_W-1:0]  mem_rdata;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == ST_IDLE);

  // effective modulus: zero acts as one, clamp to MAX_BUCKETS
  assign buck_ext = {2'b00, buckets};
  always_comb begin
    if (buck_ext == 8'd0) begin
      n_eff = NW'(1);
    end else if (buck_ext > 8'(MAX_BUCKETS)) begin
      n_eff = NW'(MAX_BUCKETS);
    end else begin
      n_eff = NW'(buck_ext);
    end
  end

  assign key_sel = side ? dst : src;
  assign mul_sel = (row == RW'(0)) ? mul0 : mul1;
  assign add_sel = (row == RW'(0)) ? add0 : add1;
  assign prod_calc =
    {{(tdcms_pkg::PROD_W - tdcms_pkg::KEY_W){1'b0}}, key_sel} *
    {{(tdcms_pkg::PROD_W - tdcms_pkg::MUL_W){1'b0}}, mul_sel} +
    {{(tdcms_pkg::PROD_W - tdcms_pkg::ADD_W){1'b0}}, add_sel};

  assign factor = (decay > tdcms_pkg::DECAY_ONE) ? tdcms_pkg::DECAY_ONE : decay;
  assign dprod_calc =
    {{tdcms_pkg::DECAY_W{1'b0}}, mem_rdata} *
    {{tdcms_pkg::COUNT_W{1'b0}}, factor};

  assign cell_addr = AW'(32'(row) * (MAX_BUCKETS * MAX_BUCKETS)
                       + 32'(sb) * MAX_BUCKETS + 32'(db));

  assign sat_sum = {1'b0, mem_rdata} + {{(tdcms_pkg::COUNT_W + 1 - tdcms_pkg::WEIGHT_W){1'b0}},
                                        weight};
  assign sat_val = sat_sum[tdcms_pkg::COUNT_W] ? '1 : sat_sum[tdcms_pkg::COUNT_W-1:0];

  assign mod_req.start    = (state == ST_MODGO);
  assign mod_req.dividend = prod;

  tdcms_mod_unit #(
    .MAX_BUCKETS (MAX_BUCKETS)
  ) u_mod (
    .clk       (clk),
    .rst       (rst),
    .req       (mod_req),
    .modulus   (n_eff),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr;
    mem_wdata = '0;
    mem_raddr = addr;
    case (state)
      ST_SWEEP: begin
        mem_we = 1'b1;
      end
      ST_RD: begin
        mem_raddr = cell_addr;
      end
      ST_UPD: begin
        mem_we    = (kind == tdcms_pkg::REQ_INSERT);
        mem_waddr = cell_addr;
        mem_wdata = sat_val;
      end
      ST_DWR: begin
        mem_we    = 1'b1;
        mem_wdata = dprod[tdcms_pkg::COUNT_W+15:16];
      end
      default: begin
      end
    endcase
  end

  tdcms_table #(
    .DEPTH (DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_SWEEP;
      sweep_reply   <= 1'b0;
      addr          <= '0;
      row           <= '0;
      side          <= 1'b0;
      m_axis_tvalid <= 1'b0;
      mul0          <= tdcms_pkg::MUL0_RST;
      add0          <= tdcms_pkg::ADD0_RST;
      mul1          <= tdcms_pkg::MUL1_RST;
      add1          <= tdcms_pkg::ADD1_RST;
      buckets       <= tdcms_pkg::BUCK_RST;
      decay         <= tdcms_pkg::DECAY_RST;
    end else begin
      if (cfg_valid) begin
        case (tdcms_pkg::cfg_idx_t'(cfg_index))
          tdcms_pkg::CFG_MUL0:  mul0    <= cfg_data[tdcms_pkg::MUL_W-1:0];
          tdcms_pkg::CFG_ADD0:  add0    <= cfg_data[tdcms_pkg::ADD_W-1:0];
          tdcms_pkg::CFG_MUL1:  mul1    <= cfg_data[tdcms_pkg::MUL_W-1:0];
          tdcms_pkg::CFG_ADD1:  add1    <= cfg_data[tdcms_pkg::ADD_W-1:0];
          tdcms_pkg::CFG_BUCK:  buckets <= cfg_data[tdcms_pkg::BUCK_W-1:0];
          tdcms_pkg::CFG_DECAY: decay   <= cfg_data;
          default: begin
          end
        endcase
      end

      if (m_axis_tvalid && m_axis_tready && state != ST_OUT) begin
        m_axis_tvalid <= 1'b0;
      end

      case (state)
        ST_SWEEP: begin
          addr <= addr + 1'b1;
          if (addr == AW'(DEPTH - 1)) begin
            state <= sweep_reply ? ST_OUT : ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            kind   <= tdcms_pkg::req_kind_t'(s_axis_tuser);
            src    <= s_axis_tdata[tdcms_pkg::KEY_W-1:0];
            dst    <= s_axis_tdata[2*tdcms_pkg::KEY_W-1:tdcms_pkg::KEY_W];
            weight <= s_axis_tdata[tdcms_pkg::DATA_IN_W-1:2*tdcms_pkg::KEY_W];
            row    <= '0;
            side   <= 1'b0;
            best   <= '1;
            addr   <= '0;
            case (tdcms_pkg::req_kind_t'(s_axis_tuser))
              tdcms_pkg::REQ_INSERT: state <= ST_MUL;
              tdcms_pkg::REQ_QUERY:  state <= ST_MUL;
              tdcms_pkg::REQ_DECAY:  state <= ST_DRD;
              default: begin
                sweep_reply <= 1'b1;
                state       <= ST_SWEEP;
              end
            endcase
          end
        end
        ST_MUL: begin
          prod  <= prod_calc;
          state <= ST_MODGO;
        end
        ST_MODGO: begin
          state <= ST_MODWAIT;
        end
        ST_MODWAIT: begin
          if (mod_done) begin
            if (!side) begin
              sb    <= mod_rem;
              side  <= 1'b1;
              state <= ST_MUL;
            end else begin
              db    <= mod_rem;
              state <= ST_RD;
            end
          end
        end
        ST_RD: begin
          state <= ST_UPD;
        end
        ST_UPD: begin
          if (mem_rdata < best) begin
            best <= mem_rdata;
          end
          side <= 1'b0;
          row  <= row + 1'b1;
          if (row == RW'(ROWS - 1)) begin
            state <= ST_OUT;
          end else begin
            state <= ST_MUL;
          end
        end
        ST_DRD: begin
          state <= ST_DMUL;
        end
        ST_DMUL: begin
          dprod <= dprod_calc;
          state <= ST_DWR;
        end
        ST_DWR: begin
          addr <= addr + 1'b1;
          if (addr == AW'(DEPTH - 1)) begin
            state <= ST_OUT;
          end else begin
            state <= ST_DRD;
          end
        end
        ST_OUT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tuser  <= kind;
            m_axis_tdata  <= (kind == tdcms_pkg::REQ_QUERY) ? best : '0;
            sweep_reply   <= 1'b0;
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("item accepted while previous item in flight");

  a_mod_done_expected: assert property (@(posedge clk) disable iff (rst)
    mod_done |-> (state == ST_MODWAIT))
    else $error("modulo result arrived outside its wait state");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state != ST_IDLE && state != ST_OUT))
    else $error("table written while no request is active");

  a_result_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> ($past(state) == ST_OUT))
    else $error("result loaded outside the result state");

endmodule
`default_nettype wire

// ===== tb/tb_two_dim_count_min_sketch.sv =====
// self-checking testbench of the two-dimensional count-min sketch
module tb_two_dim_count_min_sketch;
  timeunit 1ns;
  timeprecision 1ps;
  import tdcms_pkg::*;

  localparam int MAXB        = 32;
  localparam int ROW_CNT     = 2;
  localparam int CELL_CNT    = ROW_CNT * MAXB * MAXB;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int DRAIN_WAIT  = 64;
  localparam int SAT_INSERTS = 260;

  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_B = 3'd7;

  typedef struct packed {
    req_kind_t           kind;
    logic [KEY_W-1:0]    src;
    logic [KEY_W-1:0]    dst;
    logic [WEIGHT_W-1:0] weight;
    logic                pinned;
    logic [COUNT_W-1:0]  count;
  } probe_row_t;

  typedef struct packed {
    req_kind_t          kind;
    logic [COUNT_W-1:0] count;
  } sketch_result_t;

  localparam probe_row_t PROBE_ROWS [0:17] = '{
    '{REQ_QUERY,  32'h00000000, 32'h00000000, 24'h000000, 1'b1, 32'h0},
    '{REQ_QUERY,  32'hFFFFFFFF, 32'hFFFFFFFF, 24'hFFFFFF, 1'b1, 32'h0},
    '{REQ_INSERT, 32'h00000000, 32'h00000000, 24'hFFFFFF, 1'b1, 32'h0},
    '{REQ_INSERT, 32'hFFFFFFFF, 32'hFFFFFFFF, 24'h000000, 1'b1, 32'h0},
    '{REQ_INSERT, 32'hFFFFFFFF, 32'h00000000, 24'h000001, 1'b1, 32'h0},
    '{REQ_INSERT, 32'h00000000, 32'hFFFFFFFF, 24'h800000, 1'b1, 32'h0},
    '{REQ_QUERY,  32'h00000000, 32'h00000000, 24'h000000, 1'b0, 32'h0},
    '{REQ_QUERY,  32'hFFFFFFFF, 32'h00000000, 24'h000000, 1'b0, 32'h0},
    '{REQ_QUERY,  32'h00000000, 32'hFFFFFFFF, 24'h000000, 1'b0, 32'h0},
    '{REQ_QUERY,  32'hFFFFFFFF, 32'hFFFFFFFF, 24'h000000, 1'b0, 32'h0},
    '{REQ_DECAY,  32'h00000000, 32'h00000000, 24'h000000, 1'b1, 32'h0},
    '{REQ_QUERY,  32'h00000000, 32'h00000000, 24'h000000, 1'b0, 32'h0},
    '{REQ_QUERY,  32'h00000000, 32'hFFFFFFFF, 24'h000000, 1'b0, 32'h0},
    '{REQ_INSERT, 32'h12345678, 32'h9ABCDEF0, 24'hABCDEF, 1'b1, 32'h0},
    '{REQ_QUERY,  32'h12345678, 32'h9ABCDEF0, 24'h000000, 1'b0, 32'h0},
    '{REQ_CLEAR,  32'h00000000, 32'h00000000, 24'h000000, 1'b1, 32'h0},
    '{REQ_QUERY,  32'h00000000, 32'h00000000, 24'h000000, 1'b1, 32'h0},
    '{REQ_QUERY,  32'h12345678, 32'h9ABCDEF0, 24'h000000, 1'b1, 32'h0}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [DATA_IN_W-1:0]  s_axis_tdata;  // src_key, dst_key, weight
  logic [KIND_W-1:0]     s_axis_tuser;  // req_type
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [COUNT_W-1:0]    m_axis_tdata;  // count_value
  logic [KIND_W-1:0]     m_axis_tuser;  // done_kind

  // expectation typed into the probe table travels beside the item
  logic               pin_on;
  logic [COUNT_W-1:0] pin_count;

  logic [COUNT_W-1:0] sketch_cells [0:CELL_CNT-1];
  logic [MUL_W-1:0]   mul_q [0:1];
  logic [ADD_W-1:0]   add_q [0:1];
  logic [BUCK_W-1:0]  buck_q;
  logic [DECAY_W-1:0] decay_q;

  sketch_result_t awaited_results [$];
  int  kind_seen [0:3];
  int  results_checked = 0;
  int  reg_writes = 0;
  int  mismatches = 0;
  int  cycles = 0;
  int  sends_issued = 0;
  int  taken_results = 0;
  bit  src_calm = 1'b0;
  bit  sink_calm = 1'b0;

  logic [KEY_W-1:0] pool_src [0:5];
  logic [KEY_W-1:0] pool_dst [0:5];

  two_dim_count_min_sketch dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #4 clk = ~clk;

  function automatic logic [5:0] bucket_pick(logic [KEY_W-1:0] key, int row);
    logic [37:0] span;
    logic [37:0] prod;
    span = (buck_q == 0) ? 38'd1 : (buck_q > MAXB) ? 38'(MAXB) : 38'(buck_q);
    prod = 38'(key) * 38'(mul_q[row]) + 38'(add_q[row]);
    return 6'(prod % span);
  endfunction

  function automatic int cell_at(int row, logic [KEY_W-1:0] s, logic [KEY_W-1:0] d);
    return (row * MAXB + int'(bucket_pick(s, row))) * MAXB + int'(bucket_pick(d, row));
  endfunction

  // updates the sketch copy and returns the count the block should report
  function automatic logic [COUNT_W-1:0] sketch_apply(req_kind_t k, logic [KEY_W-1:0] s,
                                                      logic [KEY_W-1:0] d,
                                                      logic [WEIGHT_W-1:0] w);
    logic [COUNT_W:0]   sum;
    logic [COUNT_W-1:0] least;
    logic [48:0]        scaled;
    logic [DECAY_W-1:0] f;
    int                 c;
    least = '1;
    case (k)
      REQ_INSERT: begin
        for (int r = 0; r < ROW_CNT; r++) begin
          c = cell_at(r, s, d);
          sum = {1'b0, sketch_cells[c]} + (COUNT_W+1)'(w);
          sketch_cells[c] = sum[COUNT_W] ? '1 : sum[COUNT_W-1:0];
        end
        return '0;
      end
      REQ_QUERY: begin
        for (int r = 0; r < ROW_CNT; r++) begin
          c = cell_at(r, s, d);
          if (sketch_cells[c] < least) least = sketch_cells[c];
        end
        return least;
      end
      REQ_DECAY: begin
        f = (decay_q > DECAY_ONE) ? DECAY_ONE : decay_q;
        for (int i = 0; i < CELL_CNT; i++) begin
          scaled = 49'(sketch_cells[i]) * 49'(f);
          sketch_cells[i] = scaled[47:16];
        end
        return '0;
      end
      default: begin
        for (int i = 0; i < CELL_CNT; i++) sketch_cells[i] = '0;
        return '0;
      end
    endcase
  endfunction

  always @(posedge clk) begin : watch
    sketch_result_t     want;
    req_kind_t          k;
    logic [COUNT_W-1:0] got;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        reg_writes++;
        case (cfg_index)
          CFG_MUL0:  mul_q[0] = cfg_data[MUL_W-1:0];
          CFG_ADD0:  add_q[0] = cfg_data[ADD_W-1:0];
          CFG_MUL1:  mul_q[1] = cfg_data[MUL_W-1:0];
          CFG_ADD1:  add_q[1] = cfg_data[ADD_W-1:0];
          CFG_BUCK:  buck_q   = cfg_data[BUCK_W-1:0];
          CFG_DECAY: decay_q  = cfg_data[DECAY_W-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        k = req_kind_t'(s_axis_tuser);
        got = sketch_apply(k, s_axis_tdata[31:0], s_axis_tdata[63:32], s_axis_tdata[87:64]);
        want.kind = k;
        want.count = pin_on ? pin_count : got;
        awaited_results = {awaited_results, want};
        kind_seen[k]++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (awaited_results.size() == 0) begin
          $error("result with nothing awaited: done_kind %0d count_value %h",
                 m_axis_tuser, m_axis_tdata);
          mismatches++;
        end else begin
          want = awaited_results.pop_front();
          results_checked++;
          if (m_axis_tuser !== want.kind) begin
            $error("done_kind: expected %0d, got %0d", want.kind, m_axis_tuser);
            mismatches++;
          end
          if (m_axis_tdata !== want.count) begin
            $error("count_value: expected %h, got %h", want.count, m_axis_tdata);
            mismatches++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_two_dim_count_min_sketch failed");
      $finish;
    end
  end

  // result side: random stalls, with calm stretches
  initial begin : sink
    int gap;
    forever begin
      if (taken_results % 40 == 0) sink_calm = ($urandom_range(0, 3) == 0);
      gap = sink_calm ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
      taken_results++;
    end
  end

  task automatic send_req(input req_kind_t k, input logic [KEY_W-1:0] s,
                          input logic [KEY_W-1:0] d, input logic [WEIGHT_W-1:0] w,
                          input logic pin, input logic [COUNT_W-1:0] pinc);
    int gap;
    if (sends_issued % 40 == 0) src_calm = ($urandom_range(0, 3) == 0);
    gap = src_calm ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {w, d, s};
    s_axis_tuser  <= k;
    pin_on        <= pin;
    pin_count     <= pinc;
    do @(posedge clk); while (!s_axis_tready);
    sends_issued++;
  endtask

  // lets the acceptance edge pass first so the item accepted last is already awaited
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_config(input logic [CFG_DATA_W-1:0] m0, input logic [CFG_DATA_W-1:0] a0,
                            input logic [CFG_DATA_W-1:0] m1, input logic [CFG_DATA_W-1:0] a1,
                            input logic [CFG_DATA_W-1:0] b, input logic [CFG_DATA_W-1:0] dec);
    write_reg(CFG_MUL0, m0);
    write_reg(CFG_ADD0, a0);
    write_reg(CFG_MUL1, m1);
    write_reg(CFG_ADD1, a1);
    write_reg(CFG_BUCK, b);
    write_reg(CFG_DECAY, dec);
    cfg_valid <= 1'b0;
  endtask

  // mostly inserts and queries on a few recurring edges so counts pile up
  task automatic edge_traffic(input int n);
    int                  pick;
    int                  slot;
    req_kind_t           k;
    logic [KEY_W-1:0]    s;
    logic [KEY_W-1:0]    d;
    logic [WEIGHT_W-1:0] w;
    for (int i = 0; i < 6; i++) begin
      pool_src[i] = $urandom;
      pool_dst[i] = $urandom;
    end
    pool_src[0] = '0;
    pool_dst[0] = '1;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      k = (pick < 46) ? REQ_INSERT : (pick < 94) ? REQ_QUERY :
          (pick < 97) ? REQ_DECAY : REQ_CLEAR;
      if ($urandom_range(0, 3) != 0) begin
        slot = $urandom_range(0, 5);
        s = pool_src[slot];
        d = pool_dst[slot];
      end else begin
        s = $urandom;
        d = $urandom;
      end
      pick = $urandom_range(0, 9);
      w = (pick == 0) ? '0 : (pick == 1) ? '1 : WEIGHT_W'($urandom);
      send_req(k, s, d, w, 1'b0, '0);
    end
    settle();
  endtask

  initial begin : stimulus
    cfg_valid     <= 1'b0;
    cfg_index     <= '0;
    cfg_data      <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    pin_on        <= 1'b0;
    pin_count     <= '0;
    for (int i = 0; i < CELL_CNT; i++) sketch_cells[i] = '0;
    for (int i = 0; i < 4; i++) kind_seen[i] = 0;
    mul_q[0] = MUL0_RST;
    add_q[0] = ADD0_RST;
    mul_q[1] = MUL1_RST;
    add_q[1] = ADD1_RST;
    buck_q   = BUCK_RST;
    decay_q  = DECAY_RST;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (PROBE_ROWS[i])
      send_req(PROBE_ROWS[i].kind, PROBE_ROWS[i].src, PROBE_ROWS[i].dst,
               PROBE_ROWS[i].weight, PROBE_ROWS[i].pinned, PROBE_ROWS[i].count);
    settle();

    // zero multiplier, single bucket, decay factor above one
    write_reg(IDX_SPARE_A, CFG_DATA_W'($urandom));
    write_reg(IDX_SPARE_B, '1);
    set_config(17'd0, 17'd31, 17'd31, 17'd31, 17'd0, 17'h1FFFF);
    edge_traffic(60);

    // modulus above the maximum, decay to zero
    set_config(17'd1, 17'd0, 17'd3, 17'd7, 17'd33, 17'd0);
    edge_traffic(60);

    // two buckets only, heavy collisions, decay of exactly one
    set_config(17'd31, 17'd31, 17'd1, 17'd0, 17'd2, 17'h10000);
    edge_traffic(60);

    // drive the edge's cell in each row into saturation, then decay them
    set_config(17'd1, 17'd0, 17'd3, 17'd7, 17'd32, 17'h10000);
    for (int i = 0; i < SAT_INSERTS; i++)
      send_req(REQ_INSERT, 32'hDEADBEEF, 32'h0BADF00D, '1, 1'b0, '0);
    send_req(REQ_QUERY, 32'hDEADBEEF, 32'h0BADF00D, '0, 1'b0, '0);
    send_req(REQ_DECAY, '0, '0, '0, 1'b0, '0);
    send_req(REQ_QUERY, 32'hDEADBEEF, 32'h0BADF00D, '0, 1'b0, '0);
    settle();
    write_reg(CFG_DECAY, 17'hFFFF);
    cfg_valid <= 1'b0;
    send_req(REQ_DECAY, '0, '0, '0, 1'b0, '0);
    send_req(REQ_QUERY, 32'hDEADBEEF, 32'h0BADF00D, '0, 1'b0, '0);
    settle();

    for (int p = 0; p < 7; p++) begin
      set_config(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                 CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));
      edge_traffic(80);
    end

    repeat (DRAIN_WAIT) @(posedge clk);
    if (awaited_results.size() != 0) begin
      $error("%0d results never arrived", awaited_results.size());
      mismatches++;
    end
    $display("requests: %0d insert, %0d query, %0d decay, %0d clear; %0d register writes",
             kind_seen[REQ_INSERT], kind_seen[REQ_QUERY], kind_seen[REQ_DECAY],
             kind_seen[REQ_CLEAR], reg_writes);
    $display("%0d results compared, %0d mismatches", results_checked, mismatches);
    if (mismatches == 0) begin
      $display("tb_two_dim_count_min_sketch passed");
    end else begin
      $display("tb_two_dim_count_min_sketch failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/tdcms_pkg.sv
rtl/core/tdcms_mod_unit.sv
rtl/core/tdcms_table.sv
rtl/core/two_dim_count_min_sketch.sv
tb/tb_two_dim_count_min_sketch.sv
